// ===== hw/rtl/bdpc_pkg.sv =====
package bdpc_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   typedef logic [TIMER_BITS-1:0]    timer_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE_DELAY   = 2'd0,
      CSR_DOUBLE_PRESS_GAP = 2'd1,
      CSR_LONG_PRESS_SPAN  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   // One accepted tick as seen by the gesture classifier.
   typedef struct packed {
      logic tick;
      logic raw;
      logic qualified;
   } tick_type;

   localparam timer_type TIMER_MAX = {TIMER_BITS{1'b1}};

   function automatic timer_type sat_inc(input timer_type value);
      sat_inc = (value == TIMER_MAX) ? TIMER_MAX : value + timer_type'(1);
   endfunction

   localparam csr_data_type DEBOUNCE_DELAY_RESET   = csr_data_type'(50);
   localparam csr_data_type DOUBLE_PRESS_GAP_RESET = csr_data_type'(300);
   localparam csr_data_type LONG_PRESS_SPAN_RESET  = csr_data_type'(1000);

endpackage

// ===== hw/rtl/bdpc_if.sv =====
interface bdpc_req_if;
   logic valid;
   logic ready;
   logic raw_level;

   modport source (output valid, output raw_level, input ready);
   modport sink (input valid, input raw_level, output ready);
endinterface

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_event;
   logic       stable_level;

   modport source (output valid, output press_event, output stable_level, input ready);
   modport sink (input valid, input press_event, input stable_level, output ready);
endinterface

// ===== hw/rtl/bdpc_classifier.sv =====
module bdpc_classifier
   import bdpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tick_type     tick_info,
   input  csr_data_type double_press_gap,
   input  csr_data_type long_press_span,
   output event_type    press_event,
   output logic         stable_level
);

   logic      debounced_ff, debounced_in;
   logic      pending_ff, pending_in;
   logic      armed_ff, armed_in;
   timer_type held_ff, held_in;
   timer_type since_ff, since_in;
   event_type ev;
   timer_type held_inc;
   timer_type since_inc;
   logic      pending_kept;

   always_comb begin
      held_inc     = sat_inc(held_ff);
      since_inc    = sat_inc(since_ff);
      debounced_in = debounced_ff;
      pending_in   = pending_ff;
      armed_in     = armed_ff;
      held_in      = held_inc;
      since_in     = since_inc;
      ev           = EV_NONE;
      pending_kept = pending_ff && !(since_inc > timer_type'(double_press_gap));
      if (tick_info.qualified) begin
         pending_in = pending_kept;
         if (tick_info.raw != debounced_ff) begin
            debounced_in = tick_info.raw;
            if (tick_info.raw) begin
               if (!pending_kept) begin
                  armed_in = 1'b1;
                  held_in  = '0;
               end else begin
                  ev         = EV_DOUBLE;
                  pending_in = 1'b0;
               end
            end else if (!pending_kept && armed_ff &&
                         held_inc < timer_type'(long_press_span)) begin
               ev         = EV_SINGLE;
               pending_in = 1'b1;
               armed_in   = 1'b0;
               since_in   = '0;
            end
         end else if (tick_info.raw && armed_ff &&
                      held_inc >= timer_type'(long_press_span)) begin
            ev       = EV_LONG;
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounced_ff <= 1'b0;
         pending_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         held_ff      <= '0;
         since_ff     <= '0;
      end else if (tick_info.tick) begin
         debounced_ff <= debounced_in;
         pending_ff   <= pending_in;
         armed_ff     <= armed_in;
         held_ff      <= held_in;
         since_ff     <= since_in;
      end
   end

   assign press_event  = ev;
   assign stable_level = debounced_in;

   a_long_while_held : assert property (@(posedge clock) disable iff (reset)
      (tick_info.tick && ev == EV_LONG) |=> (debounced_ff && !armed_ff))
      else $error("Long press fired while the debounced level is not held.");

   a_single_opens_window : assert property (@(posedge clock) disable iff (reset)
      (tick_info.tick && ev == EV_SINGLE) |=> (!debounced_ff && pending_ff && since_ff == '0))
      else $error("Single press did not open the double-press window.");

   a_double_closes_window : assert property (@(posedge clock) disable iff (reset)
      (tick_info.tick && ev == EV_DOUBLE) |=> (debounced_ff && !pending_ff))
      else $error("Double press left the window open or the level released.");

endmodule

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Latency: a result is valid in the cycle after its input tick transfer.
// Throughput: one tick per cycle; the result register is refilled in the same
// cycle it is drained, so input ready only drops while a result waits unread.
// Reset is synchronous: it restores the register defaults (50, 300, 1000),
// clears all debounce and gesture state, and empties the result register.
module button_debounce_press_classifier
   import bdpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   bdpc_req_if.sink                req,
   bdpc_rsp_if.source              rsp,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  csr_data_type            csr_wdata
);

   csr_data_type debounce_delay_ff;
   csr_data_type double_press_gap_ff;
   csr_data_type long_press_span_ff;

   logic      previous_raw_ff;
   timer_type stable_ticks_ff, stable_ticks_in;
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff;
   logic      rsp_level_ff;
   tick_type  tick_info;
   event_type press_event;
   logic      stable_level;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_delay_ff   <= DEBOUNCE_DELAY_RESET;
         double_press_gap_ff <= DOUBLE_PRESS_GAP_RESET;
         long_press_span_ff  <= LONG_PRESS_SPAN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_DELAY:   debounce_delay_ff   <= csr_wdata;
            CSR_DOUBLE_PRESS_GAP: double_press_gap_ff <= csr_wdata;
            CSR_LONG_PRESS_SPAN:  long_press_span_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (req.raw_level != previous_raw_ff) begin
         stable_ticks_in = '0;
      end else begin
         stable_ticks_in = sat_inc(stable_ticks_ff);
      end
      tick_info.tick      = accept;
      tick_info.raw       = req.raw_level;
      tick_info.qualified = stable_ticks_in > timer_type'(debounce_delay_ff);
      rsp_valid_in        = accept || (rsp_valid_ff && !rsp.ready);
   end

   bdpc_classifier u_classifier (
      .clock            (clock),
      .reset            (reset),
      .tick_info        (tick_info),
      .double_press_gap (double_press_gap_ff),
      .long_press_span  (long_press_span_ff),
      .press_event      (press_event),
      .stable_level     (stable_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_raw_ff <= 1'b0;
         stable_ticks_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            previous_raw_ff <= req.raw_level;
            stable_ticks_ff <= stable_ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff <= press_event;
         rsp_level_ff <= stable_level;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.press_event  = rsp_event_ff;
   assign rsp.stable_level = rsp_level_ff;

   a_result_follows_transfer : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("An input transfer produced no result.");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req.ready)
      else $error("Input stalled while the result register is empty.");

   a_event_needs_qualified : assert property (@(posedge clock) disable iff (reset)
      (accept && !tick_info.qualified) |=> (rsp_event_ff == EV_NONE))
      else $error("An event fired on a tick that was not debounced.");

endmodule

// ===== sim/button_debounce_press_classifier_test.sv =====
`timescale 1ns / 1ps

module button_debounce_press_classifier_test;
   import bdpc_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_TICKS = 230;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      event_type press_event;
      logic      stable_level;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   csr_data_type csr_wdata;

   bdpc_req_if req_ch();
   bdpc_rsp_if rsp_ch();

   button_debounce_press_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Gesture classifier state as the block should hold it.
   csr_data_type debounce_cfg = DEBOUNCE_DELAY_RESET;
   csr_data_type gap_cfg = DOUBLE_PRESS_GAP_RESET;
   csr_data_type span_cfg = LONG_PRESS_SPAN_RESET;
   logic last_raw = 1'b0;
   timer_type steady_ticks = '0;
   logic accepted_level = 1'b0;
   logic window_open = 1'b0;
   logic press_timing = 1'b0;
   timer_type hold_ticks = '0;
   timer_type release_ticks = '0;

   tick_result_type expected_results[$];
   tick_result_type oldest;
   int mismatch_count = 0;
   int ticks_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_request = 0;
   int hold_off_left = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic timer_type count_up(input timer_type value);
      return (value == '1) ? value : value + timer_type'(1);
   endfunction

   function automatic tick_result_type classify_tick(input logic raw);
      tick_result_type outcome;
      outcome.press_event = EV_NONE;
      if (raw != last_raw) begin
         steady_ticks = '0;
      end else begin
         steady_ticks = count_up(steady_ticks);
      end
      hold_ticks = count_up(hold_ticks);
      release_ticks = count_up(release_ticks);
      if (steady_ticks > debounce_cfg) begin
         if (window_open && release_ticks > gap_cfg) begin
            window_open = 1'b0;
         end
         if (raw != accepted_level) begin
            accepted_level = raw;
            if (raw) begin
               if (!window_open) begin
                  press_timing = 1'b1;
                  hold_ticks = '0;
               end else begin
                  outcome.press_event = EV_DOUBLE;
                  window_open = 1'b0;
               end
            end else if (!window_open && press_timing && hold_ticks < span_cfg) begin
               outcome.press_event = EV_SINGLE;
               window_open = 1'b1;
               press_timing = 1'b0;
               release_ticks = '0;
            end
         end else if (raw && press_timing && hold_ticks >= span_cfg) begin
            outcome.press_event = EV_LONG;
            press_timing = 1'b0;
         end
      end
      last_raw = raw;
      outcome.stable_level = accepted_level;
      return outcome;
   endfunction

   task automatic send_tick(input logic raw);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         req_ch.raw_level <= 1'($urandom_range(1));
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.raw_level <= raw;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(classify_tick(raw));
      ticks_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                 input csr_data_type value);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_DEBOUNCE_DELAY:   debounce_cfg = value;
         CSR_DOUBLE_PRESS_GAP: gap_cfg = value;
         CSR_LONG_PRESS_SPAN:  span_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Underscores only separate the steps of a gesture for readability.
   task automatic send_pattern(input string levels);
      for (int i = 0; i < levels.len(); i++) begin
         if (levels[i] != "_") begin
            send_tick(levels[i] == "1");
         end
      end
   endtask

   task automatic send_chatter();
      repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)));
   endtask

   task automatic send_gesture();
      int press_len;
      int rest_len;
      press_len = $urandom_range(int'(debounce_cfg) + int'(span_cfg) + 4, 1);
      rest_len = $urandom_range(int'(debounce_cfg) + int'(gap_cfg) + 6, 1);
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(12, 1)) send_tick(1'($urandom_range(1)));
      end else begin
         send_chatter();
         repeat (press_len) send_tick(1'b1);
         send_chatter();
         repeat (rest_len) send_tick(1'b0);
      end
   endtask

   task automatic use_gesture_timing(input int debounce, input int gap, input int span);
      write_register(CSR_DEBOUNCE_DELAY, csr_data_type'(debounce));
      write_register(CSR_DOUBLE_PRESS_GAP, csr_data_type'(gap));
      write_register(CSR_LONG_PRESS_SPAN, csr_data_type'(span));
   endtask

   task automatic test_press_events();
      use_gesture_timing(0, 2, 3);
      send_pattern("11_111_00");
      send_pattern("11_00_11_111_00");
   endtask

   task automatic test_window_expiry();
      send_pattern("11_00_000_11_00");
   endtask

   task automatic test_release_after_span();
      send_pattern("11_0101_00_11_111_00");
   endtask

   task automatic test_zero_long_span();
      write_register(CSR_LONG_PRESS_SPAN, '0);
      send_pattern("11_1_00_11_00");
   endtask

   task automatic test_register_extremes();
      write_register(CSR_UNUSED_INDEX, '1);
      use_gesture_timing(65535, 65535, 65535);
      send_pattern("0110");
      write_register(CSR_DEBOUNCE_DELAY, '0);
      send_pattern("11_00_11_00");
      use_gesture_timing(0, 0, 3);
      send_pattern("11_00_11_00");
      write_register(CSR_LONG_PRESS_SPAN, csr_data_type'(1));
      send_pattern("111_00");
   endtask

   task automatic test_random_gestures(input int tick_count);
      int start;
      use_gesture_timing($urandom_range(3), $urandom_range(15), $urandom_range(20, 1));
      start = ticks_sent;
      while (ticks_sent - start < tick_count) send_gesture();
      drain_results();
   endtask

   task automatic test_receiver_hold_off();
      int start;
      use_gesture_timing(1, 6, 8);
      hold_off_request = 80;
      start = ticks_sent;
      while (ticks_sent - start < 40) send_gesture();
      drain_results();
   endtask

   always @(negedge clock) begin
      if (hold_off_request != 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: transfer with no expected result, actual event %0d level %0d",
                     $time, rsp_ch.press_event, rsp_ch.stable_level);
            mismatch_count++;
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_ch.press_event !== oldest.press_event) begin
               $display("%0t: press_event expected %0d actual %0d",
                        $time, oldest.press_event, rsp_ch.press_event);
               mismatch_count++;
            end
            if (rsp_ch.stable_level !== oldest.stable_level) begin
               $display("%0t: stable_level expected %0d actual %0d",
                        $time, oldest.stable_level, rsp_ch.stable_level);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.raw_level = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      send_idle_pct = 23;
      recv_idle_pct = 73;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_press_events();
      test_window_expiry();
      test_release_after_span();
      test_zero_long_span();
      test_register_extremes();
      test_random_gestures(PHASE_TICKS);

      send_idle_pct = 73;
      recv_idle_pct = 23;
      test_random_gestures(PHASE_TICKS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_hold_off();
      test_random_gestures(PHASE_TICKS);

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== button_debounce_press_classifier.f =====
hw/rtl/bdpc_pkg.sv
hw/rtl/bdpc_if.sv
hw/rtl/bdpc_classifier.sv
hw/rtl/button_debounce_press_classifier.sv
sim/button_debounce_press_classifier_test.sv
